### rtl/core/ev1527_pulse_width_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// EV1527 pulse width decoder assertion macros
// Concurrent check macros used by the decoder top level; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef EV1527_PULSE_WIDTH_DECODER_TOP_DEFINES_SVH
`define EV1527_PULSE_WIDTH_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// condition holds at every clock edge outside reset
`define EV_CHECK(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("check failed: cond");
// consequent holds in the cycle after the antecedent
`define EV_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed: ante |=> cons");
`else
`define EV_CHECK(lbl, cond)
`define EV_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/ev1527pwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EV1527 pulse width decoder package
// Widths, register codes, reset values and shared structs.
// ----------------------------------------------------------------------------
package ev1527pwd_pkg;

	localparam int FRAME_BITS_DEF = 24;
	localparam int TIME_W         = 32;
	localparam int KEY_W          = 24;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CNT_W          = 5;

	localparam logic [TIME_W-1:0] END_HIGH_MIN = 32'd200;
	localparam logic [TIME_W-1:0] END_HIGH_MAX = 32'd1100;

	localparam logic REPORT_CODE = 1'b0;
	localparam logic REPORT_END  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_HIGH_MIN = 3'd0,
		REG_SYNC_HIGH_MAX = 3'd1,
		REG_SYNC_LOW_MIN  = 3'd2,
		REG_SYNC_LOW_MAX  = 3'd3,
		REG_PERIOD_MIN    = 3'd4,
		REG_PERIOD_MAX    = 3'd5,
		REG_ONE_LOW_LIMIT = 3'd6,
		REG_END_LOW_MIN   = 3'd7
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] RST_SYNC_HIGH_MIN = 16'd250;
	localparam logic [CFG_W-1:0] RST_SYNC_HIGH_MAX = 16'd380;
	localparam logic [CFG_W-1:0] RST_SYNC_LOW_MIN  = 16'd8200;
	localparam logic [CFG_W-1:0] RST_SYNC_LOW_MAX  = 16'd8400;
	localparam logic [CFG_W-1:0] RST_PERIOD_MIN    = 16'd700;
	localparam logic [CFG_W-1:0] RST_PERIOD_MAX    = 16'd1100;
	localparam logic [CFG_W-1:0] RST_ONE_LOW_LIMIT = 16'd420;
	localparam logic [CFG_W-1:0] RST_END_LOW_MIN   = 16'd50000;

	typedef struct packed {
		logic [CFG_W-1:0] sync_high_min;
		logic [CFG_W-1:0] sync_high_max;
		logic [CFG_W-1:0] sync_low_min;
		logic [CFG_W-1:0] sync_low_max;
		logic [CFG_W-1:0] period_min;
		logic [CFG_W-1:0] period_max;
		logic [CFG_W-1:0] one_low_limit;
		logic [CFG_W-1:0] end_low_min;
	} cfg_regs_t;

	typedef struct packed {
		logic             valid;
		logic             kind;
		logic [KEY_W-1:0] key;
	} dec_res_t;

	typedef struct packed {
		logic             armed;
		logic [CNT_W-1:0] bit_count;
	} dec_stat_t;

endpackage

### rtl/core/ev1527pwd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EV1527 pulse width decoder configuration registers
// Eight 16-bit timing registers, written through the config channel.
// ----------------------------------------------------------------------------
module ev1527pwd_cfg
	import ev1527pwd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_regs_t            regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sync_high_min <= RST_SYNC_HIGH_MIN;
			regs_q.sync_high_max <= RST_SYNC_HIGH_MAX;
			regs_q.sync_low_min  <= RST_SYNC_LOW_MIN;
			regs_q.sync_low_max  <= RST_SYNC_LOW_MAX;
			regs_q.period_min    <= RST_PERIOD_MIN;
			regs_q.period_max    <= RST_PERIOD_MAX;
			regs_q.one_low_limit <= RST_ONE_LOW_LIMIT;
			regs_q.end_low_min   <= RST_END_LOW_MIN;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_SYNC_HIGH_MIN: regs_q.sync_high_min <= wr_data;
				REG_SYNC_HIGH_MAX: regs_q.sync_high_max <= wr_data;
				REG_SYNC_LOW_MIN:  regs_q.sync_low_min  <= wr_data;
				REG_SYNC_LOW_MAX:  regs_q.sync_low_max  <= wr_data;
				REG_PERIOD_MIN:    regs_q.period_min    <= wr_data;
				REG_PERIOD_MAX:    regs_q.period_max    <= wr_data;
				REG_ONE_LOW_LIMIT: regs_q.one_low_limit <= wr_data;
				REG_END_LOW_MIN:   regs_q.end_low_min   <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

### rtl/core/ev1527pwd_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EV1527 pulse width decoder edge logic
// Measures high and low times, matches sync, end gap and data bits, and
// holds the decoder state across edges.
// ----------------------------------------------------------------------------
module ev1527pwd_dec
	import ev1527pwd_pkg::*;
#(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              level,
	input  logic [TIME_W-1:0] now,
	input  cfg_regs_t         regs,
	output dec_res_t          res,
	output dec_stat_t         stat
);

	logic [TIME_W-1:0] last_edge_q;
	logic [TIME_W-1:0] high_q;
	logic [KEY_W-1:0]  shift_q;
	logic [CNT_W-1:0]  count_q;
	logic              armed_q;
	logic [KEY_W-1:0]  stored_q;

	logic [TIME_W-1:0] delta;
	logic [TIME_W:0]   period;
	logic [CNT_W:0]    next_count;
	logic [KEY_W-1:0]  next_shift;
	logic              is_sync;
	logic              is_end;
	logic              period_ok;
	logic              frame_done;

	assign delta  = now - last_edge_q;
	assign period = {1'b0, high_q} + {1'b0, delta};

	assign is_sync = (high_q >= TIME_W'(regs.sync_high_min))
		&& (high_q <= TIME_W'(regs.sync_high_max))
		&& (delta >= TIME_W'(regs.sync_low_min))
		&& (delta <= TIME_W'(regs.sync_low_max));

	assign is_end = (delta >= TIME_W'(regs.end_low_min))
		&& (high_q >= END_HIGH_MIN) && (high_q <= END_HIGH_MAX);

	assign period_ok = (period <= (TIME_W+1)'(regs.period_max))
		&& (period >= (TIME_W+1)'(regs.period_min));

	assign next_shift = {shift_q[KEY_W-2:0], (delta < TIME_W'(regs.one_low_limit))};
	assign next_count = {1'b0, count_q} + (CNT_W+1)'(1);
	assign frame_done = next_count >= (CNT_W+1)'(FRAME_BITS);

	always_comb begin
		res = '0;
		if (level && !is_sync) begin
			if (is_end) begin
				res.valid = 1'b1;
				res.kind  = REPORT_END;
				res.key   = stored_q;
			end else if (armed_q && period_ok && frame_done) begin
				res.valid = 1'b1;
				res.kind  = REPORT_CODE;
				res.key   = next_shift;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			high_q      <= '0;
			shift_q     <= '0;
			count_q     <= '0;
			armed_q     <= 1'b0;
			stored_q    <= '0;
		end else if (step) begin
			last_edge_q <= now;
			if (!level) begin
				high_q <= delta;
			end else if (is_sync) begin
				shift_q <= '0;
				count_q <= '0;
				armed_q <= 1'b1;
			end else if (!is_end && armed_q) begin
				if (!period_ok) begin
					armed_q <= 1'b0;
				end else begin
					shift_q <= next_shift;
					count_q <= next_count[CNT_W-1:0];
					if (frame_done) begin
						armed_q  <= 1'b0;
						stored_q <= next_shift;
					end
				end
			end
		end
	end

	assign stat.armed     = armed_q;
	assign stat.bit_count = count_q;

endmodule

### rtl/core/ev1527_pulse_width_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EV1527 pulse width decoder top level
// Decodes 24-bit remote codes from timestamped RF line edges.
//
//   channel | direction | handshake            | word
//   in      | sink      | in_valid / in_stall  | pin_level, edge_time
//   out     | source    | out_valid / out_stall| report_kind, key_code
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One edge per cycle unless stalled; input edge and result word are registered.
// The rate is set by the single edge register feeding the decode logic.
// An edge is held in the input register while a result word waits stalled.
// Reset loads the timing registers with their defaults, clears valid flags and decoder state.
// ----------------------------------------------------------------------------
`include "ev1527_pulse_width_decoder_top_defines.svh"

module ev1527_pulse_width_decoder_top
	import ev1527pwd_pkg::*;
#(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pin_level,
	input  logic [TIME_W-1:0]    edge_time,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 report_kind,
	output logic [KEY_W-1:0]     key_code,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_regs_t         regs;
	dec_res_t          res;
	dec_stat_t         stat;

	logic              valid_s1;
	logic              level_s1;
	logic [TIME_W-1:0] time_s1;
	logic              out_valid_q;
	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic              proc;

	assign cfg_ready = 1'b1;

	ev1527pwd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs)
	);

	// advance the held edge when the result register is free or draining
	assign proc     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= pin_level;
			time_s1  <= edge_time;
		end
	end

	ev1527pwd_dec #(
		.FRAME_BITS (FRAME_BITS)
	) u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proc),
		.level  (level_s1),
		.now    (time_s1),
		.regs   (regs),
		.res    (res),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res.valid) begin
			kind_q <= res.kind;
			key_q  <= res.key;
		end
	end

	assign out_valid   = out_valid_q;
	assign report_kind = kind_q;
	assign key_code    = key_q;

	`EV_CHECK(a_stall_needs_item, !in_stall || valid_s1)
	`EV_CHECK(a_armed_count_in_frame, !stat.armed || ({1'b0, stat.bit_count} < (CNT_W+1)'(FRAME_BITS)))
	`EV_CHECK_NEXT(a_code_disarms, proc && res.valid && (res.kind == REPORT_CODE), !stat.armed)
	`EV_CHECK_NEXT(a_result_loads, proc && res.valid, out_valid_q && (key_q == $past(res.key)))

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EV1527 pulse width decoder testbench
// Feeds timestamped line edges: a table of hand-picked edges first, then
// random sync/data/end-gap traffic under several timing register settings.
// Each word leaving the decoder is checked against a table word or an in-bench
// decode of the same edges. Both sides of the stream idle at random; the receiver
// also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
	import ev1527pwd_pkg::*;

	localparam int FRAME_LEN    = FRAME_BITS_DEF;
	localparam int TRAFFIC_SPAN = 195;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
	} code_word_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_GIVEN
	} row_chk_t;

	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	typedef struct packed {
		logic        lvl;
		logic [31:0] t;
		row_chk_t    chk;
		code_word_t  w;
	} plan_row_t;

	localparam code_word_t NO_WORD = '0;

	localparam plan_row_t DIRECTED_PLAN [27] = '{
		'{1'b1, 32'd60000,      CHK_NONE,  NO_WORD},
		'{1'b0, 32'd60200,      CHK_NONE,  NO_WORD},
		'{1'b1, 32'd110200,     CHK_GIVEN, '{REPORT_END, 24'h000000}},
		'{1'b0, 32'd111300,     CHK_NONE,  NO_WORD},
		'{1'b1, 32'd161299,     CHK_NONE,  NO_WORD},
		'{1'b0, 32'd162400,     CHK_NONE,  NO_WORD},
		'{1'b1, 32'd232400,     CHK_NONE,  NO_WORD},
		'{1'b0, 32'd232650,     CHK_NONE,  NO_WORD},
		'{1'b1, 32'd240850,     CHK_MODEL, NO_WORD},
		'{1'b0, 32'd241550,     CHK_NONE,  NO_WORD},
		'{1'b1, 32'd241850,     CHK_MODEL, NO_WORD},
		'{1'b0, 32'd242150,     CHK_NONE,  NO_WORD},
		'{1'b1, 32'd242850,     CHK_MODEL, NO_WORD},
		'{1'b0, 32'd243250,     CHK_NONE,  NO_WORD},
		'{1'b0, 32'd243600,     CHK_NONE,  NO_WORD},
		'{1'b1, 32'd244019,     CHK_MODEL, NO_WORD},
		'{1'b0, 32'd244300,     CHK_NONE,  NO_WORD},
		'{1'b1, 32'd244720,     CHK_MODEL, NO_WORD},
		'{1'b0, 32'd244721,     CHK_NONE,  NO_WORD},
		'{1'b1, 32'd245419,     CHK_MODEL, NO_WORD},
		'{1'b0, 32'hFFFF_FFFF,  CHK_NONE,  NO_WORD},
		'{1'b1, 32'hFFFF_FF00,  CHK_MODEL, NO_WORD},
		'{1'b0, 32'h0000_002C,  CHK_NONE,  NO_WORD},
		'{1'b1, 32'h0000_20FC,  CHK_MODEL, NO_WORD},
		'{1'b0, 32'h0000_1FFC,  CHK_NONE,  NO_WORD},
		'{1'b1, 32'h0000_24E4,  CHK_MODEL, NO_WORD},
		'{1'b0, 32'h0000_0000,  CHK_NONE,  NO_WORD}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 pin_level = 1'b0;
	logic [TIME_W-1:0]    edge_time = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 report_kind;
	logic [KEY_W-1:0]     key_code;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	ev1527_pulse_width_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pin_level   (pin_level),
		.edge_time   (edge_time),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.report_kind (report_kind),
		.key_code    (key_code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state as the bench sees it
	cfg_regs_t        cur_timing = '{RST_SYNC_HIGH_MIN, RST_SYNC_HIGH_MAX,
		RST_SYNC_LOW_MIN, RST_SYNC_LOW_MAX, RST_PERIOD_MIN, RST_PERIOD_MAX,
		RST_ONE_LOW_LIMIT, RST_END_LOW_MIN};
	logic [31:0]      prev_edge_t = '0;
	logic [31:0]      hi_width = '0;
	logic [KEY_W-1:0] code_shift = '0;
	logic [CNT_W-1:0] code_bits = '0;
	logic             rx_armed = 1'b0;
	logic [KEY_W-1:0] held_key = '0;

	code_word_t expected_codes [$];

	logic [31:0] now_us = '0;
	int          burst_left = 0;
	int          edges_sent = 0;
	int          code_words = 0;
	int          end_words = 0;
	int          cfg_writes = 0;
	int          timing_sets = 1;
	int          errors = 0;
	int          cycle_cnt = 0;

	rx_mode_t    rx_mode = RX_FREE;
	int          rx_mode_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	task automatic flag_error(input string what);
		errors++;
		if (errors <= PRINT_CAP)
			$display("ERROR @%0t: %s", $time, what);
	endtask

	function automatic void decode_edge(input logic lvl, input logic [31:0] t,
			output bit fired, output code_word_t w);
		logic [31:0] gap;
		logic [32:0] span;
		logic [5:0]  cnt_n;
		gap = t - prev_edge_t;
		prev_edge_t = t;
		fired = 1'b0;
		w = NO_WORD;
		if (!lvl) begin
			hi_width = gap;
		end else if (hi_width >= cur_timing.sync_high_min &&
				hi_width <= cur_timing.sync_high_max &&
				gap >= cur_timing.sync_low_min && gap <= cur_timing.sync_low_max) begin
			code_shift = '0;
			code_bits = '0;
			rx_armed = 1'b1;
		end else if (gap >= cur_timing.end_low_min && hi_width >= END_HIGH_MIN &&
				hi_width <= END_HIGH_MAX) begin
			fired = 1'b1;
			w = '{REPORT_END, held_key};
		end else if (rx_armed) begin
			span = {1'b0, hi_width} + {1'b0, gap};
			if (span > cur_timing.period_max || span < cur_timing.period_min) begin
				rx_armed = 1'b0;
			end else begin
				code_shift = {code_shift[KEY_W-2:0], gap < cur_timing.one_low_limit};
				cnt_n = code_bits + 6'd1;
				code_bits = cnt_n[CNT_W-1:0];
				if (cnt_n >= FRAME_LEN) begin
					rx_armed = 1'b0;
					held_key = code_shift;
					fired = 1'b1;
					w = '{REPORT_CODE, code_shift};
				end
			end
		end
	endfunction

	function automatic int span_pick(input int a, input int b);
		return (a <= b) ? $urandom_range(b, a) : $urandom_range(a, b);
	endfunction

	function automatic cfg_regs_t random_timing();
		cfg_regs_t c;
		c.sync_high_min = CFG_W'($urandom_range(1000, 0));
		c.sync_high_max = CFG_W'(c.sync_high_min + $urandom_range(400, 0));
		c.sync_low_min  = CFG_W'($urandom_range(20000, 1000));
		c.sync_low_max  = CFG_W'(c.sync_low_min + $urandom_range(500, 0));
		c.period_min    = CFG_W'($urandom_range(2000, 100));
		c.period_max    = CFG_W'(c.period_min + $urandom_range(1500, 0));
		c.one_low_limit = CFG_W'($urandom_range(c.period_max, 0));
		c.end_low_min   = CFG_W'($urandom_range(65535, 2000));
		return c;
	endfunction

	task automatic send_edge(input logic lvl, input logic [31:0] t, input row_chk_t chk,
			input code_word_t given);
		bit         fired;
		code_word_t w;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
			burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30)
				: $urandom_range(12, 1);
		end
		burst_left--;
		in_valid <= 1'b1;
		pin_level <= lvl;
		edge_time <= t;
		do @(negedge clk); while (in_stall);
		decode_edge(lvl, t, fired, w);
		if (chk == CHK_GIVEN)
			expected_codes.push_back(given);
		else if (chk == CHK_MODEL && fired)
			expected_codes.push_back(w);
		edges_sent++;
		@(posedge clk);
	endtask

	task automatic write_timing(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		case (idx)
			REG_SYNC_HIGH_MIN: cur_timing.sync_high_min = val;
			REG_SYNC_HIGH_MAX: cur_timing.sync_high_max = val;
			REG_SYNC_LOW_MIN:  cur_timing.sync_low_min = val;
			REG_SYNC_LOW_MAX:  cur_timing.sync_low_max = val;
			REG_PERIOD_MIN:    cur_timing.period_min = val;
			REG_PERIOD_MAX:    cur_timing.period_max = val;
			REG_ONE_LOW_LIMIT: cur_timing.one_low_limit = val;
			REG_END_LOW_MIN:   cur_timing.end_low_min = val;
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic load_timing(input cfg_regs_t c);
		write_timing(REG_SYNC_HIGH_MIN, c.sync_high_min);
		write_timing(REG_SYNC_HIGH_MAX, c.sync_high_max);
		write_timing(REG_SYNC_LOW_MIN, c.sync_low_min);
		write_timing(REG_SYNC_LOW_MAX, c.sync_low_max);
		write_timing(REG_PERIOD_MIN, c.period_min);
		write_timing(REG_PERIOD_MAX, c.period_max);
		write_timing(REG_ONE_LOW_LIMIT, c.one_low_limit);
		write_timing(REG_END_LOW_MIN, c.end_low_min);
		cfg_valid <= 1'b0;
		timing_sets++;
		@(posedge clk);
	endtask

	// drop valid, drain every pending word, let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_end_gap();
		now_us += $urandom_range(END_HIGH_MAX, END_HIGH_MIN);
		send_edge(1'b0, now_us, CHK_MODEL, NO_WORD);
		now_us += cur_timing.end_low_min + $urandom_range(30000, 0);
		send_edge(1'b1, now_us, CHK_MODEL, NO_WORD);
	endtask

	task automatic send_frame();
		int p;
		int lo;
		int ol;
		int nbits;
		now_us += span_pick(cur_timing.sync_high_min, cur_timing.sync_high_max);
		send_edge(1'b0, now_us, CHK_MODEL, NO_WORD);
		now_us += span_pick(cur_timing.sync_low_min, cur_timing.sync_low_max);
		send_edge(1'b1, now_us, CHK_MODEL, NO_WORD);
		nbits = ($urandom_range(7, 0) == 0) ? $urandom_range(FRAME_LEN + 3, 1) : FRAME_LEN;
		ol = cur_timing.one_low_limit;
		for (int b = 0; b < nbits; b++) begin
			p = span_pick(cur_timing.period_min, cur_timing.period_max);
			if ($urandom_range(1, 0) == 1 && ol != 0)
				lo = $urandom_range((ol - 1 < p) ? ol - 1 : p, 0);
			else
				lo = span_pick((ol < p) ? ol : p, p);
			now_us += p - lo;
			// corrupt an odd bit to break the frame
			if ($urandom_range(24, 0) == 0) begin
				now_us += $urandom_range(2000, 0);
				lo = $urandom_range(2000, 0);
			end
			send_edge(1'b0, now_us, CHK_MODEL, NO_WORD);
			now_us += lo;
			send_edge(1'b1, now_us, CHK_MODEL, NO_WORD);
		end
		if ($urandom_range(1, 0) == 1)
			send_end_gap();
	endtask

	task automatic run_traffic(input int n_edges);
		int stop;
		int pick;
		stop = edges_sent + n_edges;
		now_us = $urandom;
		while (edges_sent < stop) begin
			pick = $urandom_range(9, 0);
			if (pick < 7) begin
				send_frame();
			end else if (pick < 9) begin
				repeat ($urandom_range(6, 1)) begin
					if ($urandom_range(3, 0) == 0)
						now_us = $urandom;
					else
						now_us += $urandom_range(70000, 0);
					send_edge(1'($urandom_range(1, 0)), now_us, CHK_MODEL, NO_WORD);
				end
			end else begin
				send_end_gap();
			end
		end
	endtask

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(2, 0));
			rx_mode_left = $urandom_range(200, 20);
		end else begin
			rx_mode_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && edges_sent >= 150) begin
			hold_done = 1'b1;
			hold_left = 600;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(9, 0) < 3);
				default:  out_stall <= ($urandom_range(9, 0) < 7);
			endcase
		end
	end

	always @(negedge clk) begin
		code_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_codes.size() == 0) begin
				flag_error($sformatf("unexpected word kind=%0b key=%06h", report_kind,
					key_code));
			end else begin
				w = expected_codes.pop_front();
				if (report_kind !== w.kind)
					flag_error($sformatf("report_kind %0b, want %0b", report_kind, w.kind));
				if (key_code !== w.key)
					flag_error($sformatf("key_code %06h, want %06h", key_code, w.key));
				if (w.kind == REPORT_END)
					end_words++;
				else
					code_words++;
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d words pending", cycle_cnt,
			expected_codes.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < $size(DIRECTED_PLAN); i++)
			send_edge(DIRECTED_PLAN[i].lvl, DIRECTED_PLAN[i].t, DIRECTED_PLAN[i].chk,
				DIRECTED_PLAN[i].w);
		run_traffic(TRAFFIC_SPAN);
		settle();
		load_timing('0);
		run_traffic(TRAFFIC_SPAN);
		settle();
		load_timing('1);
		run_traffic(TRAFFIC_SPAN);
		settle();
		// min above max: sync and period windows never match
		load_timing('{16'd400, 16'd300, 16'd9000, 16'd8000, 16'd1200, 16'd600,
			16'd420, 16'd3000});
		run_traffic(TRAFFIC_SPAN);
		settle();
		load_timing(random_timing());
		run_traffic(TRAFFIC_SPAN);
		settle();
		load_timing(random_timing());
		run_traffic(TRAFFIC_SPAN);
		settle();
		load_timing('{RST_SYNC_HIGH_MIN, RST_SYNC_HIGH_MAX, RST_SYNC_LOW_MIN,
			RST_SYNC_LOW_MAX, RST_PERIOD_MIN, RST_PERIOD_MAX, RST_ONE_LOW_LIMIT,
			RST_END_LOW_MIN});
		run_traffic(TRAFFIC_SPAN);
		settle();
		$display("ran %0d edges under %0d timing sets (%0d register writes)", edges_sent,
			timing_sets, cfg_writes);
		$display("checked %0d completed codes and %0d end-gap reports, %0d mismatches",
			code_words, end_words, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### ev1527_pulse_width_decoder_top.f
+incdir+rtl/core
rtl/core/ev1527pwd_pkg.sv
rtl/core/ev1527pwd_cfg.sv
rtl/core/ev1527pwd_dec.sv
rtl/core/ev1527_pulse_width_decoder_top.sv
tb/tb_top.sv
